FILE: rtl/itp_pkg.sv
// ============================================================================
// itp_pkg
// Shared types for the inversion-table-to-permutation decoder.
// ============================================================================
package itp_pkg;

    // Width of a code entry and of an emitted permutation value
    localparam int unsigned VALUE_W = 5;

    // Controller states
    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } itp_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // insert the accepted code entry
        logic shift;    // result taken, advance the rank row
    } itp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last_item;    // the result on the output is the final one
    } itp_status_t;

endpackage

FILE: rtl/itp_ctrl.sv
// ============================================================================
// itp_ctrl
// Controller: loads code entries until the end flag, then emits results.
// ============================================================================
module itp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                seq_end,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  itp_pkg::itp_status_t status,
    output itp_pkg::itp_cmd_t    cmd
);
    import itp_pkg::*;

    itp_state_t state_reg;
    itp_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && seq_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready && status.last_item)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.shift = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/itp_datapath.sv
// ============================================================================
// itp_datapath
// Rank row and sequence counter. Each position keeps the rank of its element
// among the entries loaded so far; a new entry with code c takes rank c and
// every held rank >= c moves up by one. After the last entry the ranks are
// the permutation values, shifted out in index order.
// ============================================================================
module itp_datapath #(
    parameter int unsigned MAX_N = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [itp_pkg::VALUE_W-1:0]       rank_code,
    input  itp_pkg::itp_cmd_t                 cmd,
    output itp_pkg::itp_status_t              status,
    output logic [itp_pkg::VALUE_W-1:0]       perm_value,
    output logic                              run_end,
    output logic                              bad_sequence
);
    import itp_pkg::*;

    localparam int unsigned VW = $clog2(MAX_N);
    localparam int unsigned CW = $clog2(MAX_N + 1);

    logic [VW-1:0]          rank_reg  [MAX_N];
    logic [VW-1:0]          rank_next [MAX_N];
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   err_reg;
    logic                   err_next;
    logic                   has_room;
    logic                   code_too_big;
    logic [VW+VALUE_W-1:0]  head_wide;

    assign has_room     = count_reg < CW'(MAX_N);
    assign code_too_big = {{CW{1'b0}}, rank_code} > {{VALUE_W{1'b0}}, count_reg};

    // Rank lanes: insert on load, shift toward lane 0 on emit
    for (genvar i = 0; i < MAX_N; i++)
    begin : g_lane
        always_comb
        begin
            rank_next[i] = rank_reg[i];
            if (cmd.load && has_room)
            begin
                if (count_reg == CW'(i))
                begin
                    rank_next[i] = VW'(rank_code);
                end
                else if (count_reg > CW'(i))
                begin
                    if ({{VALUE_W{1'b0}}, rank_reg[i]} >= {{VW{1'b0}}, rank_code})
                    begin
                        rank_next[i] = rank_reg[i] + VW'(1);
                    end
                end
            end
            else if (cmd.shift)
            begin
                if (i < MAX_N - 1)
                begin
                    rank_next[i] = rank_reg[(i < MAX_N - 1) ? i + 1 : i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rank_reg[i] <= rank_next[i];
        end
    end

    // Entry counter and error flag
    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.load)
        begin
            if (!has_room)
            begin
                err_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                if (code_too_big)
                begin
                    err_next = 1'b1;
                end
            end
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - CW'(1);
            if (run_end)
            begin
                err_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // Result fields: lane 0 holds the next element in index order
    assign head_wide        = {{VALUE_W{1'b0}}, rank_reg[0]};
    assign perm_value       = err_reg ? '0 : head_wide[VALUE_W-1:0];
    assign run_end          = count_reg == CW'(1);
    assign bad_sequence     = err_reg;
    assign status.last_item = run_end;

endmodule

FILE: rtl/inversion_table_to_permutation.sv
// ============================================================================
// inversion_table_to_permutation
// Decodes an inversion table (Lehmer code) into the permutation it encodes.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): one request per code entry, rank_code
//   is the count of smaller earlier elements, seq_end marks the last entry.
//   Entries load at one per cycle while in_ready is high; each one updates a
//   row of rank registers, so the permutation is complete on the cycle after the last entry.
//   Output channel (out_valid/out_ready): n results, one per position in
//   index order, run_end on the last. A code above its position gives n
//   results with value 0 and bad_sequence set; more than MAX_N entries
//   gives MAX_N such results, the extra entries being dropped.
//   The first result is on the ports in the cycle after the last entry is
//   taken; the emit phase shifts the rank row one lane per taken result.
//   While results are pending in_ready is low; a stalled receiver simply
//   holds the current result on the ports until it is taken.
//   Reset clears the entry counter, error flag and controller; the rank
//   row needs no reset.
// ============================================================================
module inversion_table_to_permutation #(
    parameter int unsigned MAX_N = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [itp_pkg::VALUE_W-1:0] rank_code,
    input  logic                        seq_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [itp_pkg::VALUE_W-1:0] perm_value,
    output logic                        run_end,
    output logic                        bad_sequence
);
    import itp_pkg::*;

    itp_cmd_t    cmd;
    itp_status_t status;

    // Sequencing
    itp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .seq_end   (seq_end),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Rank row and counters
    itp_datapath #(
        .MAX_N (MAX_N)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rank_code    (rank_code),
        .cmd          (cmd),
        .status       (status),
        .perm_value   (perm_value),
        .run_end      (run_end),
        .bad_sequence (bad_sequence)
    );

endmodule

FILE: bench/inversion_table_to_permutation_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// inversion_table_to_permutation_tb
// Feeds inversion-table sequences (short, full length, bad codes, overflow
// and random) into the decoder under random idling on both channels, and
// checks every emitted element against an in-bench Lehmer-code decoder.
// ============================================================================
module inversion_table_to_permutation_tb;
    import itp_pkg::*;

    localparam int unsigned MAX_N        = 32;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_ITEMS = 80;
    localparam int unsigned REPORT_MAX   = 10;

    typedef logic [VALUE_W-1:0] value_t;

    typedef struct packed {
        value_t value;
        logic   last;
        logic   bad;
    } perm_result_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    value_t rank_code;
    logic   seq_end;
    logic   out_valid;
    logic   out_ready;
    value_t perm_value;
    logic   run_end;
    logic   bad_sequence;

    // Shadow of the decoder: codes held for the open sequence
    value_t       code_shadow [MAX_N];
    int unsigned  held_entries = 0;
    bit           seq_broken   = 1'b0;
    perm_result_t expected_perm [$];

    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    bit          idle_enable    = 1'b1;
    int unsigned stall_left     = 0;
    int unsigned quiet_cycles   = 0;

    inversion_table_to_permutation #(
        .MAX_N(MAX_N)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rank_code   (rank_code),
        .seq_end     (seq_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .perm_value  (perm_value),
        .run_end     (run_end),
        .bad_sequence(bad_sequence)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Take one accepted code; on the final entry, decode and queue the results
    function automatic void absorb_entry(input value_t code, input logic last);
        int unsigned free_vals [MAX_N];
        value_t      decoded [MAX_N];
        int unsigned free_len;
        int unsigned pick;
        perm_result_t r;
        if (held_entries < MAX_N)
        begin
            if (code > held_entries)
                seq_broken = 1'b1;
            code_shadow[held_entries] = code;
            held_entries++;
        end
        else
        begin
            seq_broken = 1'b1;
        end
        if (!last)
            return;
        if (!seq_broken)
        begin
            free_len = held_entries;
            for (int unsigned i = 0; i < held_entries; i++)
                free_vals[i] = i;
            // Walk backward, taking the code-th smallest unused value
            for (int k = int'(held_entries) - 1; k >= 0; k--)
            begin
                pick = code_shadow[k];
                if (pick >= free_len)
                    pick = free_len - 1;
                decoded[k] = value_t'(free_vals[pick]);
                for (int unsigned i = pick; i + 1 < free_len; i++)
                    free_vals[i] = free_vals[i + 1];
                free_len--;
            end
        end
        for (int unsigned k = 0; k < held_entries; k++)
        begin
            r.value = seq_broken ? '0 : decoded[k];
            r.last  = (k + 1 == held_entries);
            r.bad   = seq_broken;
            expected_perm.push_back(r);
        end
        held_entries = 0;
        seq_broken   = 1'b0;
    endfunction

    // Send one request; called at a falling edge, returns at a falling edge
    // with in_valid still high so back-to-back requests need no toggle.
    task automatic send_entry(input value_t code, input logic last);
        int unsigned gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        rank_code <= code;
        seq_end   <= last;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        absorb_entry(code, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_sequence(input value_t codes [$]);
        for (int unsigned i = 0; i < codes.size(); i++)
            send_entry(codes[i], i + 1 == codes.size());
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_perm.size() != 0);
    endtask

    // Mostly well-formed sequences; some with a bad code, overflow or noise
    task automatic send_random_sequence();
        value_t      seq [$];
        int unsigned kind;
        int unsigned len;
        int unsigned bad_pos;
        kind = $urandom_range(0, 9);
        if (kind == 8)
            len = $urandom_range(MAX_N + 1, MAX_N + 4);
        else if ($urandom_range(0, 7) == 0)
            len = $urandom_range(9, MAX_N);
        else
            len = $urandom_range(1, 8);
        for (int unsigned k = 0; k < len; k++)
        begin
            if (kind == 9)
                seq.push_back(value_t'($urandom_range(0, 31)));
            else
                seq.push_back(value_t'($urandom_range(0, k < 31 ? k : 31)));
        end
        if (kind == 7)
        begin
            bad_pos = $urandom_range(0, (len < 31 ? len : 31) - 1);
            seq[bad_pos] = value_t'($urandom_range(bad_pos + 1, 31));
        end
        send_sequence(seq);
    endtask

    // Single entries, tiny permutations, code above its position
    task automatic test_short_sequences();
        value_t seq [$];
        seq = {5'd0};                       send_sequence(seq);
        seq = {5'd31};                      send_sequence(seq);
        seq = {5'd0, 5'd1};                 send_sequence(seq);
        seq = {5'd0, 5'd0};                 send_sequence(seq);
        seq = {5'd0, 5'd1, 5'd2};           send_sequence(seq);
        seq = {5'd0, 5'd0, 5'd0};           send_sequence(seq);
        seq = {5'd0, 5'd1, 5'd0, 5'd3};     send_sequence(seq);
        seq = {5'd0, 5'd2, 5'd1};           send_sequence(seq);
    endtask

    // MAX_N entries: largest legal codes, then all zero
    task automatic test_full_length();
        value_t seq [$];
        for (int unsigned k = 0; k < MAX_N; k++)
            seq.push_back(value_t'(k));
        send_sequence(seq);
        seq.delete();
        for (int unsigned k = 0; k < MAX_N; k++)
            seq.push_back('0);
        send_sequence(seq);
    endtask

    // One entry beyond MAX_N is dropped and flags the sequence
    task automatic test_overflow();
        value_t seq [$];
        for (int unsigned k = 0; k <= MAX_N; k++)
            seq.push_back(value_t'($urandom_range(0, k < 31 ? k : 31)));
        send_sequence(seq);
    endtask

    // Sender holds off until the decoder has emptied completely
    task automatic test_pause_until_drained();
        send_random_sequence();
        wait_for_drain();
        send_random_sequence();
    endtask

    task automatic test_random_sequences();
        int unsigned start_count;
        start_count = items_sent;
        while (items_sent < start_count + RANDOM_ITEMS)
        begin
            // some sequences run with no idling at all
            idle_enable = ($urandom_range(0, 3) != 0);
            send_random_sequence();
        end
    endtask

    task automatic test_no_idling();
        idle_enable = 1'b0;
        repeat (4) send_random_sequence();
    endtask

    // Receiver: ready with random stall bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, 16);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Result check against the oldest queued expectation
    initial
    begin : result_check
        perm_result_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (expected_perm.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result: value=%0d run_end=%b bad=%b",
                                 perm_value, run_end, bad_sequence);
                end
                else
                begin
                    want = expected_perm.pop_front();
                    if (perm_value !== want.value || run_end !== want.last ||
                        bad_sequence !== want.bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"result mismatch: expected value=%0d run_end=%b ",
                                      "bad=%b, got value=%0d run_end=%b bad=%b"},
                                     want.value, want.last, want.bad,
                                     perm_value, run_end, bad_sequence);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rank_code = '0;
        seq_end   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_short_sequences();
        test_full_length();
        test_overflow();
        test_pause_until_drained();
        test_random_sequences();
        test_no_idling();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_perm.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
